/* rtl/location_value_table_update_core_defines.svh */
// Assertion macros for the location/value table update core.
// Used by the port checker; expects clk and rst_n in the scope of use.
`ifndef LOCATION_VALUE_TABLE_UPDATE_CORE_DEFINES_SVH
`define LOCATION_VALUE_TABLE_UPDATE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LVTU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LVTU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lvtu_pkg.sv */
// Package for the location/value table update core: widths, reset values,
// table entry type and controller states. No dependencies.
`timescale 1ns / 1ps

package lvtu_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 16;
    localparam int COORD_W             = 32;
    localparam int VALUE_W             = 32;
    localparam int SLOT_OUT_W          = 4;
    localparam int S_TDATA_W           = 2 * COORD_W + VALUE_W;
    localparam int M_TDATA_W           = 8;
    localparam int M_TUSER_W           = 2;
    localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 32'h0001_0000;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COORD_W-1:0] key_y;
        logic [COORD_W-1:0] key_x;
    } lvtu_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIFF,
        ST_WRITE
    } lvtu_state_t;

endpackage

/* rtl/location_value_table_update_core.sv */
// Top level of the location/value table update core: ring table in one
// synchronous memory, scanned oldest to newest. Depends on lvtu_pkg.
`timescale 1ns / 1ps

//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | update request: location and new value
//  m_*      | out       | m_tvalid/m_tready  | result: change flag, slot, append kind
//  cfg_*    | in        | cfg_wr_en          | change_threshold, no read-back
//
//  Steps: an accepted request scans the entries held, oldest first, up to a match,
//  then writes the entry and the result; a hit adds a step that forms |new - old|.
//  The scan is bound by the single memory read port, one entry per cycle, compare
//  in the cycle after the read.
//  Reset: rst_n clears ring pointers, entry count, threshold and control; the
//  table memory is not cleared and is only read at entries already written.
//  Stalls: the result sits in an output register; a new request is taken and
//  scanned meanwhile, and holds in the write step until the register frees.
module location_value_table_update_core
    import lvtu_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // s_tdata: [31:0] dest_longitude, [63:32] dest_latitude, [95:64] new_value
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata: [0] significant_change, [4:1] slot_index, [7:5] zero
    // m_tuser: [0] added_new, [1] replaced_oldest
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    input  logic                 cfg_wr_en,
    input  logic [VALUE_W-1:0]   cfg_wr_data
);

    localparam int PTR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_EXT_W = (PTR_W > SLOT_OUT_W) ? PTR_W : SLOT_OUT_W;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_DEPTH);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    // Table memory: one entry per slot, registered read port
    lvtu_entry_t mem [TABLE_DEPTH];
    lvtu_entry_t mem_rdata_reg;

    lvtu_state_t state_reg, state_next;

    // Request payload held for the whole update
    logic [COORD_W-1:0] req_x_reg, req_y_reg;
    logic [VALUE_W-1:0] req_v_reg;

    // Scan control
    logic [PTR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [PTR_W-1:0] rd_slot_reg;

    // Hit capture
    logic               hit_reg, hit_next;
    logic [PTR_W-1:0]   hit_slot_reg;
    logic [VALUE_W-1:0] old_val_reg;
    logic [VALUE_W-1:0] diff_reg;

    // Ring state and threshold
    logic [PTR_W-1:0]   oldest_reg, oldest_next;
    logic [PTR_W-1:0]   newest_reg, newest_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [VALUE_W-1:0] thr_reg;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    logic                  sig_reg, added_reg, repl_reg;
    logic [SLOT_OUT_W-1:0] slot_reg;

    // FSM outputs
    logic        accept;
    logic        issue;
    logic        match;
    logic        out_free;
    logic        do_write;
    logic [PTR_W-1:0] app_slot;
    logic [PTR_W-1:0] wr_slot;
    logic        table_full;
    logic        wr_sig;
    logic [SLOT_EXT_W-1:0] wr_slot_ext;
    lvtu_entry_t wr_entry;

    assign match = rd_vld_reg
                 && (mem_rdata_reg.key_x == req_x_reg)
                 && (mem_rdata_reg.key_y == req_y_reg);
    assign out_free   = !m_valid_reg || m_tready;
    assign table_full = (count_reg == FULL_CNT);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (match)
                    state_next = ST_DIFF;
                else if (issue_cnt_reg == count_reg)
                    state_next = ST_WRITE;
            end
            ST_DIFF:
                state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // FSM outputs and datapath selects
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        accept   = s_tvalid && (state_reg == ST_IDLE);
        issue    = (state_reg == ST_SCAN) && !match && (issue_cnt_reg < count_reg);
        do_write = (state_reg == ST_WRITE) && out_free;

        app_slot    = (count_reg == '0) ? '0 : ring_next(newest_reg);
        wr_slot     = hit_reg ? hit_slot_reg : app_slot;
        wr_sig      = hit_reg ? (diff_reg >= thr_reg) : 1'b1;
        wr_slot_ext = SLOT_EXT_W'(wr_slot);

        wr_entry.key_x = req_x_reg;
        wr_entry.key_y = req_y_reg;
        wr_entry.value = req_v_reg;

        rd_addr_next   = rd_addr_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_vld_next    = rd_vld_reg;
        hit_next       = hit_reg;
        if (accept)
        begin
            rd_addr_next   = oldest_reg;
            issue_cnt_next = '0;
            rd_vld_next    = 1'b0;
            hit_next       = 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            rd_vld_next = issue;
            if (issue)
            begin
                rd_addr_next   = ring_next(rd_addr_reg);
                issue_cnt_next = issue_cnt_reg + 1'b1;
            end
            if (match)
                hit_next = 1'b1;
        end

        oldest_next = oldest_reg;
        newest_next = newest_reg;
        count_next  = count_reg;
        if (do_write && !hit_reg)
        begin
            if (table_full)
            begin
                oldest_next = ring_next(oldest_reg);
                newest_next = ring_next(newest_reg);
            end
            else
            begin
                newest_next = app_slot;
                count_next  = count_reg + 1'b1;
            end
        end

        m_valid_next = m_valid_reg;
        if (m_tready)
            m_valid_next = 1'b0;
        if (do_write)
            m_valid_next = 1'b1;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_addr_reg   <= '0;
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            oldest_reg    <= '0;
            newest_reg    <= '0;
            count_reg     <= '0;
            thr_reg       <= THRESHOLD_RESET;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_addr_reg   <= rd_addr_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            hit_reg       <= hit_next;
            oldest_reg    <= oldest_next;
            newest_reg    <= newest_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_x_reg <= s_tdata[COORD_W-1:0];
            req_y_reg <= s_tdata[2*COORD_W-1:COORD_W];
            req_v_reg <= s_tdata[S_TDATA_W-1:2*COORD_W];
        end
        if (issue)
            rd_slot_reg <= rd_addr_reg;
        // Capture the oldest match; the scan stops on it
        if ((state_reg == ST_SCAN) && match)
        begin
            hit_slot_reg <= rd_slot_reg;
            old_val_reg  <= mem_rdata_reg.value;
        end
        if (state_reg == ST_DIFF)
            diff_reg <= (req_v_reg > old_val_reg) ? (req_v_reg - old_val_reg)
                                                  : (old_val_reg - req_v_reg);
        if (do_write)
        begin
            sig_reg   <= wr_sig;
            added_reg <= !hit_reg;
            repl_reg  <= !hit_reg && table_full;
            slot_reg  <= wr_slot_ext[SLOT_OUT_W-1:0];
        end
    end

    // Table memory: reads only in the scan, writes only in the write step,
    // so a read never meets a write to the same entry in one cycle
    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[wr_slot] <= wr_entry;
        if (issue)
            mem_rdata_reg <= mem[rd_addr_reg];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({slot_reg, sig_reg});
    assign m_tuser  = {repl_reg, added_reg};

endmodule

/* rtl/lvtu_checker.sv */
// Port checker for the location/value table update core, bound to the top.
// Depends on lvtu_pkg and the core's assertion macro header.
`timescale 1ns / 1ps
`include "location_value_table_update_core_defines.svh"

module lvtu_checker
    import lvtu_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    // Hold a stalled result unchanged
    `LVTU_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Replacing the oldest entry only happens on an append
    `LVTU_ASSERT_IMP(a_repl_is_append, m_tvalid && m_tuser[1], m_tuser[0], "replace without append")

    // Every append counts as significant
    `LVTU_ASSERT_IMP(a_append_sig, m_tvalid && m_tuser[0], m_tdata[0], "append not significant")

    // A request is taken and its result cannot appear in the next cycle
    `LVTU_ASSERT_NXT(a_no_fast_result, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result too early")

endmodule

bind location_value_table_update_core lvtu_checker u_lvtu_checker (.*);

/* bench/tb_location_value_table_update_core.sv */
`timescale 1ns / 1ps
// Self-checking bench for location_value_table_update_core: streams update requests,
// predicts each result with a behavioral ring-table model, checks results field by field.
// Depends on lvtu_pkg and the core RTL.

import lvtu_pkg::*;

// One predicted result, split into the fields carried on m_tdata and m_tuser.
typedef struct {
    logic       significant;
    logic       added;
    logic       replaced;
    logic [3:0] slot;
} update_outcome_t;

// Behavioral copy of the ring table plus the store of outcomes still owed by the core.
class table_update_scoreboard;
    bit [COORD_W-1:0] entry_x [TABLE_DEPTH_DEFAULT];
    bit [COORD_W-1:0] entry_y [TABLE_DEPTH_DEFAULT];
    bit [VALUE_W-1:0] entry_value [TABLE_DEPTH_DEFAULT];
    int unsigned      oldest;
    int unsigned      newest;
    int unsigned      fill;
    bit [VALUE_W-1:0] threshold;
    update_outcome_t  pending_outcomes[$];
    int unsigned      mismatches;

    function new();
        oldest     = 0;
        newest     = 0;
        fill       = 0;
        threshold  = THRESHOLD_RESET;
        mismatches = 0;
    endfunction

    function void set_threshold(bit [VALUE_W-1:0] t);
        threshold = t;
    endfunction

    function int unsigned next_slot(int unsigned s);
        return (s + 1) % TABLE_DEPTH_DEFAULT;
    endfunction

    // Apply one accepted request to the table and queue the outcome it must produce.
    function void note_update(bit [COORD_W-1:0] x, bit [COORD_W-1:0] y, bit [VALUE_W-1:0] v);
        update_outcome_t  o;
        int unsigned      s;
        int unsigned      n;
        bit               hit;
        bit [VALUE_W-1:0] diff;
        o.significant = 1'b0;
        o.added       = 1'b0;
        o.replaced    = 1'b0;
        o.slot        = '0;
        s   = oldest;
        hit = 1'b0;
        // Scan oldest to newest; the first matching entry wins.
        for (n = 0; n < fill && !hit; n++)
        begin
            if (entry_x[s] == x && entry_y[s] == y)
                hit = 1'b1;
            else
                s = next_slot(s);
        end
        if (hit)
        begin
            diff = (v > entry_value[s]) ? v - entry_value[s] : entry_value[s] - v;
            entry_value[s] = v;
            o.significant  = (diff >= threshold);
            o.slot         = s[3:0];
        end
        else
        begin
            o.significant = 1'b1;
            o.added       = 1'b1;
            if (fill >= TABLE_DEPTH_DEFAULT)
            begin
                oldest     = next_slot(oldest);
                newest     = next_slot(newest);
                o.replaced = 1'b1;
            end
            else
            begin
                if (fill == 0)
                begin
                    oldest = 0;
                    newest = 0;
                end
                else
                    newest = next_slot(newest);
                fill++;
            end
            entry_x[newest]     = x;
            entry_y[newest]     = y;
            entry_value[newest] = v;
            o.slot              = newest[3:0];
        end
        pending_outcomes.push_back(o);
    endfunction

    function void compare_field(string name, logic [3:0] want, logic [3:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Match one accepted result against the oldest outstanding outcome.
    function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
        update_outcome_t want;
        if (pending_outcomes.size() == 0)
        begin
            $error("result with no pending update: tdata=%h tuser=%h", tdata, tuser);
            mismatches++;
            return;
        end
        want = pending_outcomes.pop_front();
        compare_field("significant_change", want.significant, tdata[0]);
        compare_field("slot_index", want.slot, tdata[4:1]);
        compare_field("added_new", want.added, tuser[0]);
        compare_field("replaced_oldest", want.replaced, tuser[1]);
    endfunction
endclass

module tb_location_value_table_update_core;

    // Slowest legal gap between handshakes is the hold-off plus a random gap and
    // a full-table scan; the limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_REQUESTS  = 260;
    localparam int PHASE_COUNT     = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AT     = 500;
    // Drain time covers a full table scan of 16 entries plus the control steps.
    localparam int DRAIN_CYCLES    = 24;
    localparam int POOL_MAX        = 24;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // s_tdata: [31:0] dest_longitude, [63:32] dest_latitude, [95:64] new_value
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // m_tdata: [0] significant_change, [4:1] slot_index, [7:5] zero
    logic [M_TDATA_W-1:0] m_tdata;
    // m_tuser: [0] added_new, [1] replaced_oldest
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_wr_en;
    logic [VALUE_W-1:0]   cfg_wr_data;

    table_update_scoreboard tracker = new();

    // Quiet stretches: while set, the side in question never idles.
    bit          send_quiet;
    bit          accept_quiet;
    int unsigned requests_sent;
    int unsigned results_seen;

    location_value_table_update_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // Offer one update request after a random gap and hold it until accepted.
    // Valid is never lowered and raised in the same step: a zero gap keeps it high.
    task automatic send_update(input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y,
                               input bit [VALUE_W-1:0] v);
        int unsigned gap;
        gap = draw_gap(send_quiet);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        // Accepted at this edge: advance the model in acceptance order.
        tracker.note_update(x, y, v);
        requests_sent++;
        if (requests_sent % 50 == 0)
            send_quiet = ($urandom_range(0, 2) == 0);
    endtask

    // Drop valid, wait for every owed result, then let the core settle.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (tracker.pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write change_threshold; only called with the core idle.
    task automatic write_threshold(input bit [VALUE_W-1:0] t);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= t;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.set_threshold(t);
    endtask

    initial
    begin : stimulus
        bit [VALUE_W-1:0] phase_threshold [PHASE_COUNT];
        bit [COORD_W-1:0] pool_x [POOL_MAX];
        bit [COORD_W-1:0] pool_y [POOL_MAX];
        bit [VALUE_W-1:0] pool_val [POOL_MAX];
        bit [COORD_W-1:0] fresh_x;
        bit [COORD_W-1:0] fresh_y;
        bit [VALUE_W-1:0] v;
        int unsigned      p;
        int unsigned      i;
        int unsigned      n;
        int unsigned      pool_size;

        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        send_quiet    = 1'b0;
        requests_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, threshold at its reset value of 1.0.
        send_update(32'h0, 32'h0, 32'h0);                    // first append into empty table
        send_update(32'h0, 32'h0, 32'h0001_0000);            // hit, change exactly at threshold
        send_update(32'h0, 32'h0, 32'h0001_FFFF);            // hit, one below threshold
        send_update(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_update(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);    // swapped coordinates miss
        send_update(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);    // full-scale change
        send_update(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF);
        send_update(32'h0, 32'hFFFF_FFFF, 32'h1);            // x matches, y does not
        // Fill past the depth so the two oldest entries get replaced.
        for (i = 0; i < 13; i++)
            send_update(i + 1, ~i, 32'h8000_0000 + i);
        send_update(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF); // hit on new oldest
        send_update(32'h0, 32'h0, 32'h5);                    // evicted key comes back

        phase_threshold[0] = 32'h0;
        phase_threshold[1] = 32'hFFFF_FFFF;
        phase_threshold[2] = 32'h1;
        phase_threshold[3] = THRESHOLD_RESET;
        phase_threshold[4] = $urandom_range(2, 32'h0003_0000);
        phase_threshold[5] = $urandom;

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            wait_for_results();
            write_threshold(phase_threshold[p]);

            // Fresh key: append, then a full-scale change, then no change at all.
            fresh_x = $urandom;
            fresh_y = $urandom;
            send_update(fresh_x, fresh_y, 32'h0);
            send_update(fresh_x, fresh_y, 32'hFFFF_FFFF);
            send_update(fresh_x, fresh_y, 32'hFFFF_FFFF);

            // Alternate a pool that fits the table (mostly hits) with one that
            // overflows it (steady replacement of the oldest entry).
            pool_size = (p % 2 == 0) ? 12 : POOL_MAX;
            for (i = 0; i < pool_size; i++)
            begin
                pool_x[i]   = (i > 0 && $urandom_range(0, 3) == 0) ? pool_x[i-1] : $urandom;
                pool_y[i]   = $urandom;
                pool_val[i] = $urandom_range(0, 32'h0004_0000);
            end

            for (n = 0; n < PHASE_REQUESTS; n++)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    i = $urandom_range(0, pool_size - 1);
                    // Aim the new value at the threshold boundary half of the time.
                    case ($urandom_range(0, 5))
                        0:       v = pool_val[i] + phase_threshold[p];
                        1:       v = pool_val[i] - phase_threshold[p];
                        2:       v = pool_val[i] + phase_threshold[p] - 1;
                        3:       v = pool_val[i] + $urandom_range(0, 32'h0002_0000);
                        4:       v = $urandom;
                        default: v = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
                    endcase
                    pool_val[i] = v;
                    send_update(pool_x[i], pool_y[i], v);
                end
                else
                    send_update($urandom, $urandom, $urandom);
            end
        end

        wait_for_results();
        if (tracker.mismatches == 0 && tracker.pending_outcomes.size() == 0)
            $display("location_value_table_update_core regression: pass");
        else
            $display("location_value_table_update_core regression: fail");
        $finish;
    end

    // Result side: random ready gaps, quiet stretches, and one long hold-off
    // that fills the core and back-pressures the request side.
    initial
    begin : result_sink
        int unsigned gap;
        m_tready     = 1'b0;
        accept_quiet = 1'b0;
        results_seen = 0;
        @(posedge rst_n);
        forever
        begin
            if (results_seen == HOLD_OFF_AT)
                gap = HOLD_OFF_CYCLES;
            else
                gap = draw_gap(accept_quiet);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            tracker.check_result(m_tdata, m_tuser);
            results_seen++;
            if (results_seen % 50 == 0)
                accept_quiet = ($urandom_range(0, 2) == 0);
        end
    end

    // Hang detector: count edges with no handshake on either side.
    initial
    begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("location_value_table_update_core regression: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/lvtu_pkg.sv
rtl/location_value_table_update_core.sv
rtl/lvtu_checker.sv
bench/tb_location_value_table_update_core.sv
